// File: rtl/core/i2rm_pkg.sv
`default_nettype none

package i2rm_pkg;

    // Item kinds carried in the input tuser
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_DATA  = 2'd3;

    // Completion status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NACK   = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_SLAVE_ADDRESS  = 1'b0;
    localparam logic [0:0] REG_ACK_POLL_LIMIT = 1'b1;

    localparam logic [6:0] SLAVE_ADDRESS_RESET  = 7'h38;
    localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd200;

    localparam int unsigned BITS_PER_BYTE = 8;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_A   = 5'd1,
        PH_START_B   = 5'd2,
        PH_BIT_LOW   = 5'd3,
        PH_BIT_HIGH  = 5'd4,
        PH_ACK_LOW   = 5'd5,
        PH_ACK_HIGH  = 5'd6,
        PH_WAIT      = 5'd7,
        PH_RD_LOW    = 5'd8,
        PH_RD_HIGH   = 5'd9,
        PH_MACK_LOW  = 5'd10,
        PH_MACK_HIGH = 5'd11,
        PH_STOP_A    = 5'd12,
        PH_STOP_B    = 5'd13,
        PH_STOP_C    = 5'd14
    } t_phase;

    typedef enum logic [1:0] {
        ST_ADDR_W = 2'd0,
        ST_REG    = 2'd1,
        ST_ADDR_R = 2'd2,
        ST_DATA   = 2'd3
    } t_stage;

    typedef struct packed {
        logic [6:0] slave_address;
        logic [7:0] ack_poll_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic       sda_level;
        logic [7:0] reg_address;
        logic [7:0] byte_count;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       data_request;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/i2c_register_master_top.sv
// I2C register-access master. Each input beat is one item: a tick carrying the sampled
// SDA level advances the bus by one phase, a start request opens a register write or
// read, and a data beat supplies the next write byte while data_request is set. Every
// item gives exactly one result beat with the SCL/SDA drive to apply and the transfer
// status. One item is taken per clock: the item passes an input register, the phase
// sequencer works it out in a single step and the result lands in an output register,
// so the sustained rate is one item per cycle and a held result stalls the input only
// once both registers are full. Slave address and acknowledge poll window are set through
// the APB port; the user must do this while no transfer is running, unchecked by the block.
`default_nettype none

module i2c_register_master_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Item input
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: [0] sda_level, [8:1] reg_address, [16:9] byte_count, [24:17] data_byte
    input  wire logic [31:0] i_s_axis_tdata,
    // tuser: [1:0] func
    input  wire logic [1:0]  i_s_axis_tuser,
    // Result output
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: [0] scl_level, [1] sda_drive, [9:2] read_byte, [10] data_request,
    //        [11] busy_res, [12] done_res, [14:13] status
    output logic      [15:0] o_m_axis_tdata,
    // tuser: [0] read_valid
    output logic             o_m_axis_tuser,
    // tlast: read_last
    output logic             o_m_axis_tlast,
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import i2rm_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result step_result;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;

    assign advance         = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | advance;

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.func        <= i_s_axis_tuser;
            r_in.sda_level   <= i_s_axis_tdata[0];
            r_in.reg_address <= i_s_axis_tdata[8:1];
            r_in.byte_count  <= i_s_axis_tdata[16:9];
            r_in.data_byte   <= i_s_axis_tdata[24:17];
        end
    end

    i2rm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    i2rm_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // Load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.status, r_out.done_res, r_out.busy_res,
                              r_out.data_request, r_out.read_byte, r_out.sda_drive,
                              r_out.scl_level};
    assign o_m_axis_tuser  = r_out.read_valid;
    assign o_m_axis_tlast  = r_out.read_last;

endmodule

`default_nettype wire

// File: rtl/core/i2rm_cfg.sv
`default_nettype none

module i2rm_cfg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready,
    output i2rm_pkg::t_cfg       o_cfg
);
    import i2rm_pkg::*;

    logic [6:0] r_slave_address;
    logic [7:0] r_ack_poll_limit;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address  <= SLAVE_ADDRESS_RESET;
            r_ack_poll_limit <= ACK_POLL_LIMIT_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_SLAVE_ADDRESS:  r_slave_address  <= pwdata[6:0];
                REG_ACK_POLL_LIMIT: r_ack_poll_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register on a read
    always_comb begin
        case (paddr[2])
            REG_SLAVE_ADDRESS:  prdata = {25'd0, r_slave_address};
            REG_ACK_POLL_LIMIT: prdata = {24'd0, r_ack_poll_limit};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg.slave_address  = r_slave_address;
    assign o_cfg.ack_poll_limit = r_ack_poll_limit;

endmodule

`default_nettype wire

// File: rtl/core/i2rm_engine.sv
`default_nettype none

module i2rm_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire i2rm_pkg::t_item i_item,
    input  wire i2rm_pkg::t_cfg  i_cfg,
    output i2rm_pkg::t_result    o_result
);
    import i2rm_pkg::*;

    t_phase     r_phase, n_phase;
    t_stage     r_stage, n_stage;
    logic [3:0] r_bit_index, n_bit_index;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_held_register, n_held_register;
    logic       r_is_read, n_is_read;
    logic [7:0] r_poll_count, n_poll_count;
    logic [1:0] r_line, n_line;     // bit 1 scl, bit 0 sda
    logic       r_failed, n_failed;
    logic       r_restart, n_restart;

    logic [7:0] poll_limit;
    logic [7:0] poll_inc;
    logic [3:0] bit_inc;
    logic [7:0] rd_shift;
    logic       last_byte;

    assign poll_limit = (i_cfg.ack_poll_limit == 8'd0) ? 8'd1 : i_cfg.ack_poll_limit;
    assign poll_inc   = r_poll_count + 8'd1;
    assign bit_inc    = r_bit_index + 4'd1;
    assign rd_shift   = {r_shift_byte[6:0], i_item.sda_level};
    assign last_byte  = (r_bytes_left <= 8'd1);

    // Advance the bus sequencer by one item
    always_comb begin
        n_phase         = r_phase;
        n_stage         = r_stage;
        n_bit_index     = r_bit_index;
        n_shift_byte    = r_shift_byte;
        n_bytes_left    = r_bytes_left;
        n_held_register = r_held_register;
        n_is_read       = r_is_read;
        n_poll_count    = r_poll_count;
        n_line          = r_line;
        n_failed        = r_failed;
        n_restart       = r_restart;

        o_result           = '0;

        case (i_item.func)
            FUNC_TICK: begin
                case (r_phase)
                    PH_START_A: begin
                        n_line  = 2'b10;
                        n_phase = PH_START_B;
                    end
                    PH_START_B: begin
                        n_line  = 2'b00;
                        n_phase = PH_BIT_LOW;
                    end
                    PH_BIT_LOW: begin
                        n_line  = {1'b0, r_shift_byte[7]};
                        n_phase = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH: begin
                        n_line       = {1'b1, r_shift_byte[7]};
                        n_shift_byte = {r_shift_byte[6:0], 1'b0};
                        n_bit_index  = bit_inc;
                        n_phase      = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_ACK_LOW : PH_BIT_LOW;
                    end
                    PH_ACK_LOW: begin
                        n_line       = 2'b01;
                        n_poll_count = 8'd0;
                        n_phase      = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH: begin
                        n_line = 2'b11;
                        if (!i_item.sda_level) begin
                            case (r_stage)
                                ST_ADDR_W: begin
                                    n_stage      = ST_REG;
                                    n_shift_byte = r_held_register;
                                    n_bit_index  = 4'd0;
                                    n_phase      = PH_BIT_LOW;
                                end
                                ST_REG: begin
                                    if (r_is_read) begin
                                        n_restart = 1'b1;
                                        n_phase   = PH_STOP_A;
                                    end else if (r_bytes_left == 8'd0) begin
                                        n_phase = PH_STOP_A;
                                    end else begin
                                        n_phase = PH_WAIT;
                                    end
                                end
                                ST_ADDR_R: begin
                                    n_shift_byte = 8'd0;
                                    n_bit_index  = 4'd0;
                                    n_phase      = PH_RD_LOW;
                                end
                                default: begin
                                    n_bytes_left = r_bytes_left - 8'd1;
                                    n_phase = (r_bytes_left == 8'd1) ? PH_STOP_A : PH_WAIT;
                                end
                            endcase
                        end else begin
                            n_poll_count = poll_inc;
                            if (poll_inc >= poll_limit) begin
                                n_failed  = 1'b1;
                                n_restart = 1'b0;
                                n_phase   = PH_STOP_A;
                            end
                        end
                    end
                    PH_WAIT: begin
                        n_line = 2'b01;
                    end
                    PH_RD_LOW: begin
                        n_line  = 2'b01;
                        n_phase = PH_RD_HIGH;
                    end
                    PH_RD_HIGH: begin
                        n_line       = 2'b11;
                        n_shift_byte = rd_shift;
                        n_bit_index  = bit_inc;
                        if (bit_inc >= 4'(BITS_PER_BYTE)) begin
                            o_result.read_valid = 1'b1;
                            o_result.read_byte  = rd_shift;
                            o_result.read_last  = last_byte;
                            n_phase             = PH_MACK_LOW;
                        end else begin
                            n_phase = PH_RD_LOW;
                        end
                    end
                    PH_MACK_LOW: begin
                        n_line  = {1'b0, last_byte};
                        n_phase = PH_MACK_HIGH;
                    end
                    PH_MACK_HIGH: begin
                        n_line = {1'b1, last_byte};
                        if (last_byte) begin
                            n_bytes_left = 8'd0;
                            n_phase      = PH_STOP_A;
                        end else begin
                            n_bytes_left = r_bytes_left - 8'd1;
                            n_shift_byte = 8'd0;
                            n_bit_index  = 4'd0;
                            n_phase      = PH_RD_LOW;
                        end
                    end
                    PH_STOP_A: begin
                        n_line  = 2'b00;
                        n_phase = PH_STOP_B;
                    end
                    PH_STOP_B: begin
                        n_line  = 2'b10;
                        n_phase = PH_STOP_C;
                    end
                    PH_STOP_C: begin
                        n_line = 2'b11;
                        if (r_restart) begin
                            n_restart    = 1'b0;
                            n_stage      = ST_ADDR_R;
                            n_shift_byte = {i_cfg.slave_address, 1'b1};
                            n_bit_index  = 4'd0;
                            n_phase      = PH_START_A;
                        end else begin
                            o_result.done_res = 1'b1;
                            o_result.status   = r_failed ? STATUS_NACK : STATUS_OK;
                            n_failed          = 1'b0;
                            n_phase           = PH_IDLE;
                        end
                    end
                    PH_IDLE: begin
                        n_line  = 2'b11;
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        n_line  = 2'b11;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            FUNC_DATA: begin
                // Take the next write byte only while waiting for one
                if (r_phase == PH_WAIT) begin
                    n_stage      = ST_DATA;
                    n_shift_byte = i_item.data_byte;
                    n_bit_index  = 4'd0;
                    n_phase      = PH_BIT_LOW;
                end
            end
            default: begin
                // Start request: honoured only when idle
                if (r_phase == PH_IDLE) begin
                    if (i_item.func == FUNC_READ && i_item.byte_count == 8'd0) begin
                        o_result.done_res = 1'b1;
                        o_result.status   = STATUS_REJECT;
                    end else begin
                        n_is_read       = (i_item.func == FUNC_READ);
                        n_held_register = i_item.reg_address;
                        n_bytes_left    = i_item.byte_count;
                        n_stage         = ST_ADDR_W;
                        n_failed        = 1'b0;
                        n_restart       = 1'b0;
                        n_poll_count    = 8'd0;
                        n_shift_byte    = {i_cfg.slave_address, 1'b0};
                        n_bit_index     = 4'd0;
                        n_phase         = PH_START_A;
                    end
                end
            end
        endcase

        o_result.scl_level    = n_line[1];
        o_result.sda_drive    = n_line[0];
        o_result.data_request = (n_phase == PH_WAIT);
        o_result.busy_res     = (n_phase != PH_IDLE);
    end

    // Hold sequencer state between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_stage         <= ST_ADDR_W;
            r_bit_index     <= 4'd0;
            r_shift_byte    <= 8'd0;
            r_bytes_left    <= 8'd0;
            r_held_register <= 8'd0;
            r_is_read       <= 1'b0;
            r_poll_count    <= 8'd0;
            r_line          <= 2'b11;
            r_failed        <= 1'b0;
            r_restart       <= 1'b0;
        end else if (i_step) begin
            r_phase         <= n_phase;
            r_stage         <= n_stage;
            r_bit_index     <= n_bit_index;
            r_shift_byte    <= n_shift_byte;
            r_bytes_left    <= n_bytes_left;
            r_held_register <= n_held_register;
            r_is_read       <= n_is_read;
            r_poll_count    <= n_poll_count;
            r_line          <= n_line;
            r_failed        <= n_failed;
            r_restart       <= n_restart;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/i2rm_checker.sv
`default_nettype none

module i2rm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [15:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result beat changed while stalled");

    // A received byte completes with SCL high and the transfer still running
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[0] && o_m_axis_tdata[11])
        else $error("received byte outside a running read");

    // Last marker only on a received byte
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("read_last without read_valid");

    // Finishing leaves the bus idle and released
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[12] |->
            !o_m_axis_tdata[11] && !o_m_axis_tdata[10] && o_m_axis_tdata[0]
            && o_m_axis_tdata[1])
        else $error("done while still busy or lines held");

    // Status only on a finishing beat
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[14:13] != 2'd0) |-> o_m_axis_tdata[12])
        else $error("status without done");

endmodule

bind i2c_register_master_top i2rm_checker u_checker (.*);

`default_nettype wire
